### design/bounding_box_normalize_points_core_defines.svh
// ----------------------------------------------------------------------------
// Bounding box normalize points - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BOUNDING_BOX_NORMALIZE_POINTS_CORE_DEFINES_SVH
`define BOUNDING_BOX_NORMALIZE_POINTS_CORE_DEFINES_SVH

// same-cycle implication
`define BBN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bbn_pkg.sv
// ----------------------------------------------------------------------------
// Bounding box normalize points - package
// Sizes, widths and the controller state type shared by the top level and the divider.
// ----------------------------------------------------------------------------
package bbn_pkg;

	// point store capacity
	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// data widths
	localparam int COORD_W    = 32;
	localparam int POINT_W    = 3 * COORD_W;
	localparam int NORM_W     = 17;
	localparam int QUO_W      = NORM_W - 1;
	localparam int NUM_W      = COORD_W + 2;
	localparam int DEN_W      = COORD_W + 1;
	localparam int STEP_CNT_W = $clog2(QUO_W);

	// bound reset values
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_PREP,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

### design/bounding_box_normalize_points_core.sv
// ----------------------------------------------------------------------------
// Bounding box normalize points - top level
// Loads a 3-D point cloud into a point RAM while tracking per-axis bounds,
// then emits every stored point normalized to its axis midpoint and extent.
// ----------------------------------------------------------------------------
// Loading takes one point per cycle: each item that fits in the point RAM
// is written to it and the six bound registers update in the same cycle.
// The item marked last closes the cloud and the input stalls until the
// whole run is emitted. Each stored point then passes through a RAM read,
// the forming of the midpoint offsets, a divider load, the three per-axis
// dividers (16 quotient bits, one bit a cycle) and the output cycle. After
// the result flagged run_end is taken, the block is back in its reset
// state. The point RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "bounding_box_normalize_points_core_defines.svh"

module bounding_box_normalize_points_core
	import bbn_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic                      last_point,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [NORM_W-1:0]  norm_x,
	output logic signed [NORM_W-1:0]  norm_y,
	output logic signed [NORM_W-1:0]  norm_z,
	output logic                      flat_axis,
	output logic                      overflowed,
	output logic                      run_end
);

	state_t state_q;
	state_t state_nxt;

	logic signed [COORD_W-1:0] low_x_q, high_x_q;
	logic signed [COORD_W-1:0] low_y_q, high_y_q;
	logic signed [COORD_W-1:0] low_z_q, high_z_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      dropped_q;
	logic [ADDR_W-1:0]         idx_q;

	logic                      in_acc;
	logic                      out_acc;
	logic                      has_room;
	logic                      is_final;
	logic                      div_start;
	logic                      div_busy_x, div_busy_y, div_busy_z;

	logic [POINT_W-1:0]        rd_data;
	logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
	logic signed [NUM_W-1:0]   num_x_s2, num_y_s2, num_z_s2;
	logic [DEN_W-1:0]          den_x, den_y, den_z;
	logic signed [NORM_W-1:0]  quot_x, quot_y, quot_z;
	logic                      flat_x, flat_y, flat_z;

	logic signed [NORM_W-1:0]  norm_x_q, norm_y_q, norm_z_q;
	logic                      flat_q;
	logic                      run_end_q;

	// handshakes
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign has_room = (cnt_q < CNT_W'(MAX_POINTS));
	assign is_final = ({1'b0, idx_q} + 1'b1) == cnt_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_acc && last_point) state_nxt = ST_READ;
			ST_READ:  state_nxt = ST_PREP;
			ST_PREP:  state_nxt = ST_START;
			ST_START: state_nxt = ST_DIV;
			ST_DIV:   if (!div_busy_x) state_nxt = ST_OUT;
			ST_OUT: begin
				if (out_acc) begin
					state_nxt = run_end_q ? ST_LOAD : ST_READ;
				end
			end
			default:  state_nxt = ST_LOAD;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_LOAD:  in_stall  = 1'b0;
			ST_START: div_start = 1'b1;
			ST_OUT:   out_valid = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// point count, drop flag and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
		end else if (in_acc) begin
			if (has_room) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				dropped_q <= 1'b1;
			end
			idx_q <= '0;
		end else if (out_acc) begin
			if (run_end_q) begin
				cnt_q     <= '0;
				dropped_q <= 1'b0;
				idx_q     <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// per-axis bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_x_q  <= COORD_MAX;
			high_x_q <= COORD_MIN;
			low_y_q  <= COORD_MAX;
			high_y_q <= COORD_MIN;
			low_z_q  <= COORD_MAX;
			high_z_q <= COORD_MIN;
		end else if (in_acc && has_room) begin
			if (point_x < low_x_q)  low_x_q  <= point_x;
			if (point_x > high_x_q) high_x_q <= point_x;
			if (point_y < low_y_q)  low_y_q  <= point_y;
			if (point_y > high_y_q) high_y_q <= point_y;
			if (point_z < low_z_q)  low_z_q  <= point_z;
			if (point_z > high_z_q) high_z_q <= point_z;
		end else if (out_acc && run_end_q) begin
			low_x_q  <= COORD_MAX;
			high_x_q <= COORD_MIN;
			low_y_q  <= COORD_MAX;
			high_y_q <= COORD_MIN;
			low_z_q  <= COORD_MAX;
			high_z_q <= COORD_MIN;
		end
	end

	// point store: written while loading, read while emitting
	bbn_ram #(
		.WIDTH (POINT_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc && has_room),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data ({point_z, point_y, point_x}),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign rd_x = $signed(rd_data[COORD_W-1:0]);
	assign rd_y = $signed(rd_data[2*COORD_W-1:COORD_W]);
	assign rd_z = $signed(rd_data[3*COORD_W-1:2*COORD_W]);

	// offset from the midpoint, doubled: 2p - low - high
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			num_x_s2 <= (NUM_W'(rd_x) <<< 1) - NUM_W'(low_x_q) - NUM_W'(high_x_q);
			num_y_s2 <= (NUM_W'(rd_y) <<< 1) - NUM_W'(low_y_q) - NUM_W'(high_y_q);
			num_z_s2 <= (NUM_W'(rd_z) <<< 1) - NUM_W'(low_z_q) - NUM_W'(high_z_q);
		end
	end

	// axis extents
	assign den_x = DEN_W'(high_x_q) - DEN_W'(low_x_q);
	assign den_y = DEN_W'(high_y_q) - DEN_W'(low_y_q);
	assign den_z = DEN_W'(high_z_q) - DEN_W'(low_z_q);

	assign flat_x = (high_x_q == low_x_q);
	assign flat_y = (high_y_q == low_y_q);
	assign flat_z = (high_z_q == low_z_q);

	// one divider per axis, run in lockstep
	bbn_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x_s2),
		.den    (den_x),
		.busy   (div_busy_x),
		.quot   (quot_x)
	);

	bbn_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y_s2),
		.den    (den_y),
		.busy   (div_busy_y),
		.quot   (quot_y)
	);

	bbn_div u_div_z (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_z_s2),
		.den    (den_z),
		.busy   (div_busy_z),
		.quot   (quot_z)
	);

	// output register; flat axes read as zero
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && !div_busy_x) begin
			norm_x_q  <= flat_x ? '0 : quot_x;
			norm_y_q  <= flat_y ? '0 : quot_y;
			norm_z_q  <= flat_z ? '0 : quot_z;
			flat_q    <= flat_x || flat_y || flat_z;
			run_end_q <= is_final;
		end
	end

	assign norm_x     = norm_x_q;
	assign norm_y     = norm_y_q;
	assign norm_z     = norm_z_q;
	assign flat_axis  = flat_q;
	assign overflowed = dropped_q;
	assign run_end    = run_end_q;

	// checks
	`BBN_ASSERT_SAME(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_POINTS), "point count above capacity")
	`BBN_ASSERT_SAME(a_div_lockstep, clk, arst_n, 1'b1, (div_busy_x == div_busy_y) && (div_busy_x == div_busy_z), "axis dividers out of step")
	`BBN_ASSERT_NEXT(a_drop_flag, clk, arst_n, in_acc && !has_room, dropped_q, "dropped point not flagged")
	`BBN_ASSERT_NEXT(a_run_clear, clk, arst_n, out_acc && run_end_q, (cnt_q == '0) && !dropped_q && (state_q == ST_LOAD), "state not cleared after run")
	`BBN_ASSERT_SAME(a_norm_range, clk, arst_n, out_valid, (norm_x >= -17'sd32768) && (norm_x <= 17'sd32768) && (norm_y >= -17'sd32768) && (norm_y <= 17'sd32768) && (norm_z >= -17'sd32768) && (norm_z <= 17'sd32768), "normalized value out of range")

endmodule

### design/bbn_ram.sv
// ----------------------------------------------------------------------------
// Bounding box normalize points - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

### design/bbn_div.sv
// ----------------------------------------------------------------------------
// Bounding box normalize points - axis divider
// Radix-2 restoring divider: |num| * 2^15 / den, one quotient bit a cycle,
// sign applied on the output. Caller guarantees |num| <= den.
// ----------------------------------------------------------------------------
module bbn_div
	import bbn_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]         den,
	output logic                     busy,
	output logic signed [NORM_W-1:0] quot
);

	logic [DEN_W-1:0]      rem_q;
	logic [DEN_W-1:0]      den_q;
	logic [QUO_W-1:0]      quo_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  neg_q;
	logic                  lsb_q;
	logic [NUM_W-1:0]      mag;
	logic                  shift_in;
	logic [NUM_W-1:0]      trial;
	logic [NUM_W:0]        diff;
	logic                  ge;
	logic [NORM_W-1:0]     quo_ext;

	// magnitude of the numerator
	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	// one restoring step; the numerator's low bit enters on the first step
	assign shift_in = (cnt_q == STEP_CNT_W'(QUO_W - 1)) ? lsb_q : 1'b0;
	assign trial    = {rem_q, shift_in};
	assign diff     = {1'b0, trial} - {2'b00, den_q};
	assign ge       = ~diff[NUM_W];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_CNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag[NUM_W-1:1];
			lsb_q <= mag[0];
			neg_q <= num[NUM_W-1];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	// signed result, truncated toward zero
	assign quo_ext = {1'b0, quo_q};
	assign quot    = neg_q ? $signed(NORM_W'(-quo_ext)) : $signed(quo_ext);
	assign busy    = busy_q;

endmodule
